/* design/sliding_median_outlier_flag_assert.svh */
// assertion macros for the sliding median outlier flag checker
`ifndef SLIDING_MEDIAN_OUTLIER_FLAG_ASSERT_SVH
`define SLIDING_MEDIAN_OUTLIER_FLAG_ASSERT_SVH

// same-cycle implication, held off during reset
`define SMOF_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define SMOF_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

/* design/smof_pkg.sv */
// shared types and constants for the sliding median outlier flag
`default_nettype none

package smof_pkg;

	// largest window the cell row holds by default
	localparam int MAX_WINDOW_DEF = 64;

	// configuration register width and reset value
	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd5;

	// stream widths
	localparam int SAMPLE_W = 32;
	localparam int OUT_TDATA_W = 8;

	// result codes
	typedef enum logic [1:0] {
		STATUS_WARMUP  = 2'd0,
		STATUS_NORMAL  = 2'd1,
		STATUS_OUTLIER = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_RANK,
		S_PICK,
		S_SUM,
		S_CMP,
		S_DONE
	} state_t;

	// commands from the sequencer to every cell
	typedef struct packed {
		logic init;
		logic rotate;
		logic count;
		logic load;
	} ctrl_t;

endpackage

`default_nettype wire

/* design/smof_cell.sv */
// one cell of the window row: a stored sample with its rank counts
`default_nettype none

module smof_cell #(
	parameter int CW = 7
) (
	input  wire                       clk,
	input  smof_pkg::ctrl_t           ctrl,
	input  wire                       win_init,
	input  wire signed [smof_pkg::SAMPLE_W-1:0] prev_val,
	input  wire signed [smof_pkg::SAMPLE_W-1:0] nxt_val,
	input  wire [CW-1:0]              nxt_lt,
	input  wire [CW-1:0]              nxt_le,
	input  wire                       nxt_win,
	input  wire signed [smof_pkg::SAMPLE_W-1:0] bcast_val,
	input  wire                       bcast_win,
	output logic signed [smof_pkg::SAMPLE_W-1:0] val,
	output logic [CW-1:0]             lt_nx,
	output logic [CW-1:0]             le_nx,
	output logic                      win
);

	logic signed [smof_pkg::SAMPLE_W-1:0] val_q;
	logic [CW-1:0] lt_q;
	logic [CW-1:0] le_q;
	logic          win_q;
	logic          inc_lt;
	logic          inc_le;

	// compare the broadcast window sample with the one held here
	always_comb begin
		inc_lt = ctrl.count && bcast_win && (bcast_val < val_q);
		inc_le = ctrl.count && bcast_win && (bcast_val <= val_q);
		lt_nx  = lt_q + CW'(inc_lt);
		le_nx  = le_q + CW'(inc_le);
	end

	// clear counts and set the window flag, rotate around the ring, or take a new sample from behind
	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			lt_q  <= '0;
			le_q  <= '0;
			win_q <= win_init;
		end else if (ctrl.rotate) begin
			val_q <= nxt_val;
			lt_q  <= nxt_lt;
			le_q  <= nxt_le;
			win_q <= nxt_win;
		end else if (ctrl.load) begin
			val_q <= prev_val;
		end
	end

	assign val = val_q;
	assign win = win_q;

endmodule

`default_nettype wire

/* design/sliding_median_outlier_flag.sv */
// top level: window cell row, rank sequencer and outlier compare
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata[31:0] sample
//  m_*       out  m_tvalid/m_tready  m_tdata[1:0] status, [7:2] zero
//  cfg_*     in   cfg_we             cfg_wdata[6:0] window_size
//
// an item that finds the window still filling skips the ring turns and goes from accept to hand-over
// a full window takes one turn of the ring to count ranks,
// a second turn to pick the middle samples, then sum, compare and hand over
// one item is in work at a time; the result register lets the next item in
// while m_tready is low, and that item waits in its last step for the register
// arst_n clears the sequencer, fill and turn counts, result valid and window_size (to 5)
`default_nettype none

module sliding_median_outlier_flag #(
	parameter int MAX_WINDOW = smof_pkg::MAX_WINDOW_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire [smof_pkg::SAMPLE_W-1:0]        s_tdata,    // [31:0] sample
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [smof_pkg::OUT_TDATA_W-1:0]    m_tdata,    // [1:0] status
	input  wire                                 cfg_we,
	input  wire [smof_pkg::CFG_W-1:0]           cfg_wdata   // [6:0] window_size
);

	localparam int N  = MAX_WINDOW;
	localparam int CW = $clog2(N + 1);
	localparam int EW = (CW > smof_pkg::CFG_W) ? CW : smof_pkg::CFG_W;
	localparam int SW = smof_pkg::SAMPLE_W;

	smof_pkg::state_t  state_q, state_d;
	smof_pkg::ctrl_t   ctrl;
	smof_pkg::status_t status_q, m_status_q;

	logic [smof_pkg::CFG_W-1:0] win_cfg_q;
	logic [EW-1:0]              cfg_ext;
	logic [CW-1:0]              w_eff;
	logic [CW-1:0]              k_lo, k_hi;
	logic [CW-1:0]              filled_q;
	logic [CW-1:0]              cnt_q;
	logic                       cnt_last;
	logic                       warm;
	logic                       out_load;
	logic                       m_tvalid_q;

	logic signed [SW-1:0]       sample_q;
	logic signed [SW-1:0]       lo_q, hi_q;
	logic signed [SW:0]         dsum_s1;
	logic signed [SW+2:0]       d3;
	logic signed [SW+2:0]       x2;

	logic signed [SW-1:0]       val_w [N];
	logic [CW-1:0]              lt_w  [N];
	logic [CW-1:0]              le_w  [N];
	logic                       win_w [N];

	// effective window: zero acts as one, clipped to the ring length
	always_comb begin
		cfg_ext = EW'(win_cfg_q);
		if (cfg_ext == '0) begin
			w_eff = CW'(1);
		end else if (cfg_ext > EW'(N)) begin
			w_eff = CW'(N);
		end else begin
			w_eff = CW'(cfg_ext);
		end
		k_lo = (w_eff - CW'(1)) >> 1;
		k_hi = w_eff >> 1;
	end

	assign warm     = filled_q < w_eff;
	assign cnt_last = cnt_q == CW'(N - 1);

	// row of cells; cell 0 holds the newest sample and feeds the broadcast
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic signed [SW-1:0] prev_v;
		if (i == 0) begin : g_head
			assign prev_v = sample_q;
		end else begin : g_body
			assign prev_v = val_w[i-1];
		end
		smof_cell #(
			.CW (CW)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.win_init  (CW'(i) < w_eff),
			.prev_val  (prev_v),
			.nxt_val   (val_w[(i+1)%N]),
			.nxt_lt    (lt_w[(i+1)%N]),
			.nxt_le    (le_w[(i+1)%N]),
			.nxt_win   (win_w[(i+1)%N]),
			.bcast_val (val_w[0]),
			.bcast_win (win_w[0]),
			.val       (val_w[i]),
			.lt_nx     (lt_w[i]),
			.le_nx     (le_w[i]),
			.win       (win_w[i])
		);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smof_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and cell commands
	always_comb begin
		state_d     = state_q;
		ctrl        = '0;
		s_tready    = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			smof_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctrl.init = 1'b1;
					state_d   = warm ? smof_pkg::S_DONE : smof_pkg::S_RANK;
				end
			end
			smof_pkg::S_RANK: begin
				ctrl.rotate = 1'b1;
				ctrl.count  = 1'b1;
				if (cnt_last) begin
					state_d = smof_pkg::S_PICK;
				end
			end
			smof_pkg::S_PICK: begin
				ctrl.rotate = 1'b1;
				if (cnt_last) begin
					state_d = smof_pkg::S_SUM;
				end
			end
			smof_pkg::S_SUM: begin
				state_d = smof_pkg::S_CMP;
			end
			smof_pkg::S_CMP: begin
				state_d = smof_pkg::S_DONE;
			end
			smof_pkg::S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					ctrl.load = 1'b1;
					out_load  = 1'b1;
					state_d   = smof_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = smof_pkg::S_IDLE;
			end
		endcase
	end

	// control registers: window size, fill count, turn counter, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cfg_q  <= smof_pkg::WINDOW_RESET;
			filled_q   <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				win_cfg_q <= cfg_wdata;
			end
			if (ctrl.load && filled_q != CW'(N)) begin
				filled_q <= filled_q + CW'(1);
			end
			if (ctrl.rotate) begin
				cnt_q <= cnt_last ? '0 : cnt_q + CW'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// three times the doubled median against doubled sample, on widened values
	assign d3 = (SW+3)'(dsum_s1) + ((SW+3)'(dsum_s1) <<< 1);
	assign x2 = (SW+3)'(sample_q) <<< 1;

	// payload: sample, middle samples, sum, status and output status
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_q <= s_tdata;
			status_q <= smof_pkg::STATUS_WARMUP;
		end
		if (state_q == smof_pkg::S_PICK && win_w[0]) begin
			if (lt_w[0] <= k_lo && k_lo < le_w[0]) begin
				lo_q <= val_w[0];
			end
			if (lt_w[0] <= k_hi && k_hi < le_w[0]) begin
				hi_q <= val_w[0];
			end
		end
		if (state_q == smof_pkg::S_SUM) begin
			dsum_s1 <= (SW+1)'(lo_q) + (SW+1)'(hi_q);
		end
		if (state_q == smof_pkg::S_CMP) begin
			status_q <= (d3 >= x2) ? smof_pkg::STATUS_NORMAL : smof_pkg::STATUS_OUTLIER;
		end
		if (out_load) begin
			m_status_q <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(smof_pkg::OUT_TDATA_W-2)'(0), m_status_q};

endmodule

`default_nettype wire

/* design/smof_checker.sv */
// port checker for the sliding median outlier flag, bound to the top level
`default_nettype none
`include "sliding_median_outlier_flag_assert.svh"

module smof_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              s_tvalid,
	input wire                              s_tready,
	input wire                              m_tvalid,
	input wire                              m_tready,
	input wire [smof_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	// a waiting result keeps its value
	`SMOF_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// one item at a time: ready drops right after an item is taken
	`SMOF_ASSERT_NXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready, "second item taken while busy")

	// status is one of the three result codes
	`SMOF_ASSERT_NOW(a_status_code, clk, arst_n, m_tvalid, m_tdata[1:0] != 2'd3, "status code out of range")

	// padding above the status stays zero
	`SMOF_ASSERT_NOW(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[7:2] == 6'd0, "result padding not zero")

endmodule

bind sliding_median_outlier_flag smof_checker u_smof_checker (.*);

`default_nettype wire
